>>> src/bfi_pkg.sv
// Shared types, constants and codes of the Bloom filter insert unit.
package bfi_pkg;

  localparam int FILTER_BITS  = 256;
  localparam int WORD_W       = 64;
  localparam int FILTER_WORDS = FILTER_BITS / WORD_W;
  localparam int POS_W        = $clog2(FILTER_BITS);
  localparam int KEY_W        = 32;
  localparam int COUNT_W      = 5;
  localparam int CFG_IDX_W    = 8;
  localparam int BYTES_PER_HASH = 8;
  localparam int MAX_HASHES   = 16;

  localparam logic [COUNT_W-1:0] COARSE_RESET = COUNT_W'(6);
  localparam logic [COUNT_W-1:0] FINE_RESET   = COUNT_W'(8);

  localparam logic [63:0] MIX_MULT  = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] MIX_SEED  = MIX_MULT << 3;
  localparam int          MIX_SHIFT = 47;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Command field codes.
  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COARSE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FINE   = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_INSERT,
    OP_READ
  } op_code_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key_value;
    logic             use_fine;
  } in_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] filter_word3;
    logic [WORD_W-1:0] filter_word2;
    logic [WORD_W-1:0] filter_word1;
    logic [WORD_W-1:0] filter_word0;
  } out_req_t;

  // One classified request on its way from the front to the back.
  typedef struct packed {
    op_code_t         op;
    logic [KEY_W-1:0] key;
    logic [COUNT_W-1:0] count;
  } bfi_op_t;

endpackage

>>> src/bloom_filter_insert_unit.sv
// Top level of the Bloom filter insert unit: front end, request queue and back end.
//
// Usage. Requests enter through a queue-style port: a request is taken at a rising
// edge where in_push is high and in_full is low. A request carries a command (clear,
// insert key or read filter), a 32-bit key and a flag that picks the fine or the
// coarse hash count. Reads return the four 64-bit filter words on out_data, which is
// valid while out_empty is low and is taken at an edge with out_pop high.
// The hash counts are written over the cfg_ port while the unit is idle; index 0 is
// the coarse count, index 1 the fine count, other indexes are ignored.
// A clear or a read is done as the back end takes it from the queue; a read result
// passes through the queue register and then the result register. An insert holds
// the back end while it hashes: after taking it from the queue, for each batch of up
// to eight filter bits it forms four 64-bit products on the single shared 32x32
// multiplier, each in a low, a middle and a high step, and then sets the bits.
// Requests that do nothing occupy no back-end time.
// Reset clears the filter, empties the queue and the result register and loads the
// default hash counts (six coarse, eight fine). If the receiver stalls, the result
// is held, the back end stops at the next read, and in_full rises once the queue fills.
module bloom_filter_insert_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  bfi_pkg::in_req_t              in_data,
  output logic                          out_empty,
  input  logic                          out_pop,
  output bfi_pkg::out_req_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bfi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfi_pkg::COUNT_W-1:0]   cfg_data
);
  import bfi_pkg::*;

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  bfi_op_t q_entry;
  bfi_op_t q_head;

  // Register writes are always taken at once.
  assign cfg_ready = 1'b1;

  // in_full follows the queue: a request that is dropped as a no-op still waits for room,
  // which keeps acceptance independent of the payload.
  assign in_full = q_full;

  bfi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  bfi_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty)
  );

  bfi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

>>> src/bfi_queue.sv
// Short first-in first-out queue of classified requests between front and back.
module bfi_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bfi_pkg::bfi_op_t push_entry,
  output logic            full,
  input  logic            pop,
  output bfi_pkg::bfi_op_t head,
  output logic            empty
);
  import bfi_pkg::*;

  bfi_op_t              entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   fill_r;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (fill_r == Q_CNT_W'(Q_DEPTH));
  assign empty   = (fill_r == '0);
  assign head    = entry_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> src/bfi_front.sv
// Front end: hash count registers and classification of incoming requests.
module bfi_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  input  bfi_pkg::in_req_t              in_data,
  input  logic                          cfg_valid,
  input  logic [bfi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfi_pkg::COUNT_W-1:0]   cfg_data,
  input  logic                          q_full,
  output logic                          q_push,
  output bfi_pkg::bfi_op_t              q_entry
);
  import bfi_pkg::*;

  logic [COUNT_W-1:0] coarse_r;
  logic [COUNT_W-1:0] fine_r;
  logic [COUNT_W-1:0] raw_count;
  logic [COUNT_W-1:0] sat_count;
  logic               keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coarse_r <= COARSE_RESET;
      fine_r   <= FINE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_COARSE) begin
        coarse_r <= cfg_data;
      end else if (cfg_index == REG_FINE) begin
        fine_r <= cfg_data;
      end
    end
  end

  assign raw_count = in_data.use_fine ? fine_r : coarse_r;
  assign sat_count = (raw_count > COUNT_W'(MAX_HASHES)) ? COUNT_W'(MAX_HASHES) : raw_count;

  // Unused commands and inserts that set no bits never reach the back end.
  always_comb begin
    q_entry.key   = in_data.key_value;
    q_entry.count = sat_count;
    q_entry.op    = OP_CLEAR;
    keep          = 1'b0;
    case (in_data.command)
      CMD_CLEAR: begin
        q_entry.op = OP_CLEAR;
        keep       = 1'b1;
      end
      CMD_INSERT: begin
        q_entry.op = OP_INSERT;
        keep       = (sat_count != '0);
      end
      CMD_READ: begin
        q_entry.op = OP_READ;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push = in_push && !q_full && keep;

endmodule

>>> src/bfi_back.sv
// Back end: iterative hash sequencer, filter register and result register.
module bfi_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  bfi_pkg::bfi_op_t  q_head,
  output logic              q_pop,
  input  logic              out_pop,
  output logic              out_empty,
  output bfi_pkg::out_req_t out_data
);
  import bfi_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_MID,
    ST_MUL_HI,
    ST_SET
  } state_t;

  state_t               state_r;
  logic [63:0]          v_r;
  logic [63:0]          p_r;
  logic [31:0]          c_r;
  logic [1:0]           phase_r;
  logic [COUNT_W-1:0]   remain_r;
  logic [FILTER_BITS-1:0] filter_r;
  logic                 out_valid_r;
  out_req_t             out_data_r;

  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [63:0]          prod;
  logic [63:0]          mul_res;
  logic [63:0]          post_res;
  logic [COUNT_W-1:0]   batch;
  logic [FILTER_BITS-1:0] set_mask;

  // One shared 32x32 multiplier; a 64-bit product modulo 2^64 takes three steps.
  always_comb begin
    mul_a = v_r[31:0];
    mul_b = MIX_MULT[31:0];
    case (state_r)
      ST_MUL_MID: mul_b = MIX_MULT[63:32];
      ST_MUL_HI:  mul_a = v_r[63:32];
      default:    mul_b = MIX_MULT[31:0];
    endcase
  end

  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign mul_res = {c_r + prod[31:0], p_r[31:0]};

  always_comb begin
    if (phase_r == 2'd1) begin
      post_res = mul_res ^ MIX_SEED;
    end else begin
      post_res = mul_res ^ (mul_res >> MIX_SHIFT);
    end
  end

  assign batch = (remain_r > COUNT_W'(BYTES_PER_HASH)) ? COUNT_W'(BYTES_PER_HASH) : remain_r;

  always_comb begin
    set_mask = '0;
    for (int n = 0; n < BYTES_PER_HASH; n++) begin
      if (COUNT_W'(n) < batch) begin
        set_mask[v_r[8*n +: POS_W]] = 1'b1;
      end
    end
  end

  assign q_pop = (state_r == ST_IDLE) && !q_empty &&
                 ((q_head.op != OP_READ) || !out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      filter_r    <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      remain_r    <= '0;
    end else begin
      if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_pop) begin
            case (q_head.op)
              OP_CLEAR: begin
                filter_r <= '0;
              end
              OP_INSERT: begin
                v_r      <= {32'd0, q_head.key};
                remain_r <= q_head.count;
                phase_r  <= '0;
                state_r  <= ST_MUL_LO;
              end
              OP_READ: begin
                out_valid_r <= 1'b1;
                out_data_r  <= filter_r;
              end
              default: begin
                state_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_MUL_LO: begin
          p_r     <= prod;
          state_r <= ST_MUL_MID;
        end
        ST_MUL_MID: begin
          c_r     <= p_r[63:32] + prod[31:0];
          state_r <= ST_MUL_HI;
        end
        ST_MUL_HI: begin
          v_r     <= post_res;
          phase_r <= phase_r + 1'b1;
          state_r <= (phase_r == 2'd3) ? ST_SET : ST_MUL_LO;
        end
        ST_SET: begin
          filter_r <= filter_r | set_mask;
          if (remain_r > COUNT_W'(BYTES_PER_HASH)) begin
            remain_r <= remain_r - COUNT_W'(BYTES_PER_HASH);
            phase_r  <= '0;
            state_r  <= ST_MUL_LO;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/bfi_checker.sv
// Port-level checks of the Bloom filter insert unit and their binding to it.
module bfi_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_push,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input bfi_pkg::out_req_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending after reset");

  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input queue full after reset");

  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push && !in_full))
    else $error("input queue filled without a request");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result changed or vanished");

endmodule

bind bloom_filter_insert_unit bfi_checker u_bfi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
